[hdl/vrs_pkg.sv]
// Package for the Verlet rope tick: sizes, constants, point record and helpers.
// Used by the point store, the iterative units, the top level and the testbench.
// No dependencies.
package vrs_pkg;

  localparam int NUM_POINTS = 16;
  localparam int IDX_W      = $clog2(NUM_POINTS);
  localparam int ACC_W      = 17 + IDX_W;

  // Gravity step 9.81 * 0.016^2 as an unsigned Q0.32 fraction.
  localparam logic [23:0] GRAV_STEP_Q32 = 24'd10786209;

  // Reciprocal of the point count for the gravity factor, exact over the
  // range of elasticity * index.
  localparam int          RECIP_SH = 30;
  localparam logic [30:0] RECIP    = 31'((64'd1 << RECIP_SH) / NUM_POINTS + 64'd1);

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_LEN    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELASTICITY = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_END    = 8'd3;

  typedef struct packed {
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] old_x;
    logic signed [31:0] old_y;
  } point_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sh0080000000) begin
      r = -32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/vrs_if.sv]
// Channel interfaces of the rope tick block: tick request, point results, register writes.
// No dependencies.
interface vrs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] base_x;
  logic signed [31:0] base_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  modport source(output valid, base_x, base_y, end_x, end_y, input ready);
  modport sink(input valid, base_x, base_y, end_x, end_y, output ready);
endinterface

interface vrs_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         point_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic               last;
  modport source(output valid, point_index, pos_x, pos_y, last, input ready);
  modport sink(input valid, point_index, pos_x, pos_y, last, output ready);
endinterface

interface vrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hdl/vrs_state_mem.sv]
// Point store: one record (current and previous position) per rope point.
// Synchronous write, registered read. Depends on vrs_pkg.
module vrs_state_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [vrs_pkg::IDX_W-1:0] waddr,
  input  vrs_pkg::point_t           wdata,
  input  logic                      re,
  input  logic [vrs_pkg::IDX_W-1:0] raddr,
  output vrs_pkg::point_t           rdata
);
  import vrs_pkg::*;

  point_t mem [NUM_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/vrs_sqrt.sv]
// Iterative floor square root of a 63-bit value, one result bit per cycle.
// Depends on vrs_pkg.
module vrs_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [62:0] val,
  output logic        done,
  output logic [31:0] root
);
  import vrs_pkg::*;

  logic [63:0] v_r, res_r, bit_r;
  logic        run_r, done_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;
  assign done  = done_r;
  assign root  = res_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r   <= {1'b0, val};
        res_r <= '0;
        bit_r <= 64'd1 << 62;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/vrs_div.sv]
// Restoring divider for the correction ratio floor(num * 2^30 / den), num <= den.
// One quotient bit per cycle, 31 quotient bits in all. Depends on vrs_pkg.
module vrs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [30:0] quot
);
  import vrs_pkg::*;

  logic [34:0] rem_r;
  logic [32:0] den_r;
  logic [30:0] q_r;
  logic [4:0]  cnt_r;
  logic        run_r, done_r;
  logic [34:0] rem2;

  // The first step compares the dividend itself, which gives the top quotient bit
  // when num equals den.
  assign rem2 = (cnt_r == 5'd0) ? rem_r : {rem_r[33:0], 1'b0};
  assign done = done_r;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= {2'b0, num};
        den_r <= den;
        q_r   <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (rem2 >= {2'b0, den_r}) begin
          rem_r <= rem2 - {2'b0, den_r};
          q_r   <= {q_r[29:0], 1'b1};
        end else begin
          rem_r <= rem2;
          q_r   <= {q_r[29:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/verlet_rope_step.sv]
// Verlet rope tick: a hanging rope of NUM_POINTS points with a distance constraint.
// Each request on in_ch is one simulation tick carrying the base and end positions.
// The block then answers with NUM_POINTS results on out_ch, point 0 first, with
// last set on the final point. Only one tick is in work at a time: in_ch.ready is
// high only while the block is idle, and it rises again after the last point leaves.
// Every segment takes a square root of its squared length; a segment that is too long
// also runs a divide for the correction ratio after the root, and both of its ends
// are moved. Setup and write-back states frame the segments; the first tick after reset
// first lays the rope out, and each point is read back from the point store to emit it.
// When out_ch stalls, the current point is held and the block waits. Registers on cfg_ch
// are taken at any time (cfg_ch.ready is high)
// but should be written only while idle. Reset restores the register defaults and
// marks the rope as not laid out; the first tick lays it straight down from the base.
// Depends on vrs_pkg, vrs_if, vrs_state_mem, vrs_sqrt and vrs_div.
module verlet_rope_step (
  input logic       clk,
  input logic       rst_n,
  vrs_in_if.sink    in_ch,
  vrs_out_if.source out_ch,
  vrs_cfg_if.sink   cfg_ch
);
  import vrs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LAY, S_RD0, S_RD0W, S_PRD, S_PMUL, S_PVEL, S_PGRAV, S_PDIFF,
    S_PSQ, S_PSUM, S_PSQS, S_PSQRT, S_PCMP, S_PDIV, S_PHMUL, S_PHAPP,
    S_PWB, S_LASTWB, S_ERD, S_EOUT
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);

  state_t state_r;

  logic [30:0] seg_len_r;
  logic [16:0] elast_r, damp_r;
  logic        pin_r, laid_r;

  logic signed [31:0] bx_r, by_r, ex_r, ey_r;
  logic [IDX_W-1:0]   idx_r;
  logic signed [39:0] lay_y_r;

  logic signed [31:0] px_r, py_r;
  logic signed [31:0] prev_x_r, prev_y_r, prev_ox_r, prev_oy_r;
  logic signed [31:0] cx_r, cy_r;
  logic [ACC_W-1:0]   acc_r;
  logic [16:0]        q_r;
  logic signed [50:0] vmx_r, vmy_r;
  logic signed [35:0] vy_r;
  logic signed [42:0] gmul_r;
  logic signed [32:0] dx_r, dy_r;
  logic [30:0]        sx_r, sy_r;
  logic               k_r;
  logic [61:0]        sqx_r, sqy_r;
  logic [62:0]        sum_r;
  logic [32:0]        dist_r;
  logic [30:0]        r_r;
  logic signed [63:0] hmx_r, hmy_r;

  // Memory port and unit controls.
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  point_t           mem_wdata, mem_rdata;
  logic             sq_start, sq_done, dv_start, dv_done;
  logic [31:0]      sq_root;
  logic [30:0]      dv_quot;

  vrs_state_mem u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  vrs_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .val  (sum_r),
    .done (sq_done),
    .root (sq_root)
  );

  vrs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(dv_start),
    .num  (dist_r - {2'b0, seg_len_r}),
    .den  (dist_r),
    .done (dv_done),
    .quot (dv_quot)
  );

  assign sq_start = (state_r == S_PSQS);
  assign dv_start = (state_r == S_PCMP) && (dist_r > {2'b0, seg_len_r});

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = '{cur_x: prev_x_r, cur_y: prev_y_r, old_x: prev_ox_r, old_y: prev_oy_r};
    case (state_r)
      S_LAY: begin
        mem_we    = 1'b1;
        mem_wdata = '{cur_x: bx_r, cur_y: sat32(lay_y_r),
                      old_x: bx_r, old_y: sat32(lay_y_r)};
      end
      S_PWB: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r - IDX_W'(1);
      end
      S_LASTWB: begin
        mem_we = 1'b1;
        if (pin_r) begin
          mem_wdata = '{cur_x: ex_r, cur_y: ey_r, old_x: ex_r, old_y: ey_r};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re    = (state_r == S_RD0) || (state_r == S_PRD) || (state_r == S_ERD);
  assign mem_raddr = (state_r == S_RD0) ? '0 : idx_r;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = (state_r == S_EOUT);
  assign out_ch.point_index = 6'(idx_r);
  assign out_ch.pos_x       = mem_rdata.cur_x;
  assign out_ch.pos_y       = mem_rdata.cur_y;
  assign out_ch.last        = (idx_r == LAST_IDX);

  // Datapath terms used by single states.
  logic signed [17:0] factor;
  logic signed [51:0] vx_rnd, vy_rnd;
  logic signed [43:0] grav_rnd;
  logic signed [32:0] dx_nxt, dy_nxt;
  logic [32:0]        ax, ay;
  logic               k_nxt;
  logic signed [64:0] hx_rnd, hy_rnd;
  logic [ACC_W+30:0]  q_prod;

  assign factor   = 18'sd65536 - $signed({1'b0, q_r});
  assign vx_rnd   = {vmx_r[50], vmx_r} + 52'sd32768;
  assign vy_rnd   = {vmy_r[50], vmy_r} + 52'sd32768;
  assign grav_rnd = -{gmul_r[42], gmul_r} + 44'sd2147483648;
  assign dx_nxt   = {cx_r[31], cx_r} - {prev_x_r[31], prev_x_r};
  assign dy_nxt   = {cy_r[31], cy_r} - {prev_y_r[31], prev_y_r};
  assign ax       = dx_nxt[32] ? 33'(-dx_nxt) : 33'(dx_nxt);
  assign ay       = dy_nxt[32] ? 33'(-dy_nxt) : 33'(dy_nxt);
  assign k_nxt    = ax[32] | ax[31] | ay[32] | ay[31];
  assign hx_rnd   = {hmx_r[63], hmx_r} + 65'sd1073741824;
  assign hy_rnd   = {hmy_r[63], hmy_r} + 65'sd1073741824;
  assign q_prod   = acc_r * RECIP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      seg_len_r <= 31'd65536;
      elast_r   <= 17'd32768;
      damp_r    <= 17'd64225;
      pin_r     <= 1'b0;
      laid_r    <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_SEG_LEN:    seg_len_r <= cfg_ch.data[30:0];
          CFG_ELASTICITY: elast_r   <= cfg_ch.data[16:0];
          CFG_DAMPING:    damp_r    <= cfg_ch.data[16:0];
          CFG_PIN_END:    pin_r     <= cfg_ch.data[0];
          default:        ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            bx_r    <= in_ch.base_x;
            by_r    <= in_ch.base_y;
            ex_r    <= in_ch.end_x;
            ey_r    <= in_ch.end_y;
            lay_y_r <= 40'(in_ch.base_y);
            idx_r   <= '0;
            state_r <= laid_r ? S_RD0 : S_LAY;
          end
        end
        S_LAY: begin
          lay_y_r <= lay_y_r - $signed({9'b0, seg_len_r});
          if (idx_r == LAST_IDX) begin
            laid_r  <= 1'b1;
            state_r <= S_RD0;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        S_RD0: begin
          state_r <= S_RD0W;
        end
        S_RD0W: begin
          // Point 0 is pinned to the base; its previous position is kept as stored.
          prev_x_r  <= bx_r;
          prev_y_r  <= by_r;
          prev_ox_r <= mem_rdata.old_x;
          prev_oy_r <= mem_rdata.old_y;
          idx_r     <= IDX_W'(1);
          state_r   <= S_PRD;
        end
        S_PRD: begin
          acc_r   <= ACC_W'(elast_r) * ACC_W'(idx_r);
          state_r <= S_PMUL;
        end
        S_PMUL: begin
          px_r    <= mem_rdata.cur_x;
          py_r    <= mem_rdata.cur_y;
          vmx_r   <= $signed({mem_rdata.cur_x[31], mem_rdata.cur_x}
                      - {mem_rdata.old_x[31], mem_rdata.old_x}) * $signed({1'b0, damp_r});
          vmy_r   <= $signed({mem_rdata.cur_y[31], mem_rdata.cur_y}
                      - {mem_rdata.old_y[31], mem_rdata.old_y}) * $signed({1'b0, damp_r});
          q_r     <= q_prod[RECIP_SH +: 17];
          state_r <= S_PVEL;
        end
        S_PVEL: begin
          cx_r    <= sat32(40'(px_r) + 40'($signed(vx_rnd[51:16])));
          vy_r    <= vy_rnd[51:16];
          gmul_r  <= $signed({1'b0, GRAV_STEP_Q32}) * factor;
          state_r <= S_PGRAV;
        end
        S_PGRAV: begin
          cy_r    <= sat32(40'(py_r) + 40'(vy_r) + 40'($signed(grav_rnd[43:32])));
          state_r <= S_PDIFF;
        end
        S_PDIFF: begin
          dx_r    <= dx_nxt;
          dy_r    <= dy_nxt;
          k_r     <= k_nxt;
          sx_r    <= k_nxt ? ax[31:1] : ax[30:0];
          sy_r    <= k_nxt ? ay[31:1] : ay[30:0];
          state_r <= S_PSQ;
        end
        S_PSQ: begin
          sqx_r   <= sx_r * sx_r;
          sqy_r   <= sy_r * sy_r;
          state_r <= S_PSUM;
        end
        S_PSUM: begin
          sum_r   <= {1'b0, sqx_r} + {1'b0, sqy_r};
          state_r <= S_PSQS;
        end
        S_PSQS: begin
          state_r <= S_PSQRT;
        end
        S_PSQRT: begin
          if (sq_done) begin
            dist_r  <= k_r ? {sq_root, 1'b0} : {1'b0, sq_root};
            state_r <= S_PCMP;
          end
        end
        S_PCMP: begin
          state_r <= dv_start ? S_PDIV : S_PWB;
        end
        S_PDIV: begin
          if (dv_done) begin
            r_r     <= dv_quot;
            state_r <= S_PHMUL;
          end
        end
        S_PHMUL: begin
          hmx_r   <= dx_r * $signed({1'b0, r_r});
          hmy_r   <= dy_r * $signed({1'b0, r_r});
          state_r <= S_PHAPP;
        end
        S_PHAPP: begin
          // Half the correction goes to each end of the segment.
          cx_r     <= sat32(40'(cx_r) - 40'($signed(hx_rnd[64:31])));
          cy_r     <= sat32(40'(cy_r) - 40'($signed(hy_rnd[64:31])));
          prev_x_r <= sat32(40'(prev_x_r) + 40'($signed(hx_rnd[64:31])));
          prev_y_r <= sat32(40'(prev_y_r) + 40'($signed(hy_rnd[64:31])));
          state_r  <= S_PWB;
        end
        S_PWB: begin
          // Point idx-1 is final now and has been written back.
          prev_x_r  <= cx_r;
          prev_y_r  <= cy_r;
          prev_ox_r <= px_r;
          prev_oy_r <= py_r;
          if (idx_r == LAST_IDX) begin
            state_r <= S_LASTWB;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_PRD;
          end
        end
        S_LASTWB: begin
          idx_r   <= '0;
          state_r <= S_ERD;
        end
        S_ERD: begin
          state_r <= S_EOUT;
        end
        S_EOUT: begin
          if (out_ch.ready) begin
            if (idx_r == LAST_IDX) begin
              idx_r   <= '0;
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= S_ERD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[verif/tb_vrs_ifs.sv]
// Testbench-side note: the channel interfaces themselves live in hdl/vrs_if.sv.
// This file holds the tick request and point result records used by the testbench.
// No dependencies.
`timescale 1ns / 1ps
package tb_vrs_types;
  typedef struct {
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } tick_req_t;

  typedef struct {
    logic [5:0]         point_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               last;
  } point_res_t;
endpackage

[verif/tb.sv]
// Testbench for verlet_rope_step: random and directed ticks checked against a
// Q16.16 rope predictor. Depends on vrs_pkg, vrs_if and tb_vrs_types.
`timescale 1ns / 1ps
module tb;
  import vrs_pkg::*;
  import tb_vrs_types::*;

  localparam int LIMIT = 40000;
  localparam int HOLD_LEN = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  vrs_in_if  in_ch();
  vrs_out_if out_ch();
  vrs_cfg_if cfg_ch();

  verlet_rope_step i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                          .cfg_ch(cfg_ch));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state.
  logic [30:0] seg_len;
  logic [16:0] elast;
  logic [16:0] damp;
  logic        pin_last;
  logic signed [31:0] px[NUM_POINTS];
  logic signed [31:0] py[NUM_POINTS];
  logic signed [31:0] ox[NUM_POINTS];
  logic signed [31:0] oy[NUM_POINTS];
  logic        laid;

  point_res_t expected_points[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off = 0;
  bit  hold_req = 1'b0;
  bit  hold_ack = 1'b0;
  bit  done = 1'b0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic apply_constraint(int i);
    longint dx, dy, hx, hy;
    longint unsigned ax, ay, seg_dist, r;
    int k;
    dx = longint'(px[i]) - longint'(px[i-1]);
    dy = longint'(py[i]) - longint'(py[i-1]);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    k = ((ax >> 31) | (ay >> 31)) != 0 ? 1 : 0;
    ax = ax >> k;
    ay = ay >> k;
    seg_dist = floor_sqrt(ax * ax + ay * ay) << k;
    if (seg_dist > longint'(seg_len)) begin
      r = ((seg_dist - seg_len) << 30) / seg_dist;
      hx = round_sh(dx * longint'(r), 31);
      hy = round_sh(dy * longint'(r), 31);
      px[i] = clamp32(longint'(px[i]) - hx);
      py[i] = clamp32(longint'(py[i]) - hy);
      px[i-1] = clamp32(longint'(px[i-1]) + hx);
      py[i-1] = clamp32(longint'(py[i-1]) + hy);
    end
  endtask

  // Advances the predicted rope by one tick and queues its point positions.
  task automatic predict_tick(tick_req_t t);
    longint cx, cy, factor, grav, vx, vy;
    point_res_t p;
    if (!laid) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        px[i] = t.base_x;
        py[i] = clamp32(longint'(t.base_y) - longint'(i) * longint'(seg_len));
        ox[i] = px[i];
        oy[i] = py[i];
      end
      laid = 1'b1;
    end
    px[0] = t.base_x;
    py[0] = t.base_y;
    for (int i = 1; i < NUM_POINTS; i++) begin
      cx = px[i];
      cy = py[i];
      factor = 65536 - longint'((longint'(elast) * i) / NUM_POINTS);
      grav = round_sh(-(longint'(10786209) * factor), 32);
      vx = round_sh((cx - longint'(ox[i])) * longint'(damp), 16);
      vy = round_sh((cy - longint'(oy[i])) * longint'(damp), 16);
      px[i] = clamp32(cx + vx);
      py[i] = clamp32(cy + vy + grav);
      ox[i] = cx[31:0];
      oy[i] = cy[31:0];
      apply_constraint(i);
    end
    if (pin_last) begin
      px[NUM_POINTS-1] = t.end_x;
      py[NUM_POINTS-1] = t.end_y;
      ox[NUM_POINTS-1] = t.end_x;
      oy[NUM_POINTS-1] = t.end_y;
    end
    for (int i = 0; i < NUM_POINTS; i++) begin
      p.point_index = i[5:0];
      p.pos_x = px[i];
      p.pos_y = py[i];
      p.last = (i == NUM_POINTS - 1);
      expected_points = {expected_points, p};
    end
  endtask

  task automatic send_tick(tick_req_t t);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.base_x <= t.base_x;
    in_ch.base_y <= t.base_y;
    in_ch.end_x <= t.end_x;
    in_ch.end_y <= t.end_y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_tick(t);
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_SEG_LEN:    seg_len = val[30:0];
      CFG_ELASTICITY: elast = val[16:0];
      CFG_DAMPING:    damp = val[16:0];
      CFG_PIN_END:    pin_last = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_points.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5, 0))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(2 * 65536, 0) - 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic tick_req_t rand_tick();
    tick_req_t t;
    // Mostly a rope moving around a nearby base, now and then wild values.
    if ($urandom_range(9, 0) < 7) begin
      t.base_x = $urandom_range(40 * 65536, 0) - 20 * 65536;
      t.base_y = $urandom_range(40 * 65536, 0) - 20 * 65536;
      t.end_x = $urandom_range(40 * 65536, 0) - 20 * 65536;
      t.end_y = $urandom_range(40 * 65536, 0) - 20 * 65536;
    end else begin
      t.base_x = rand_word();
      t.base_y = rand_word();
      t.end_x = rand_word();
      t.end_y = rand_word();
    end
    return t;
  endfunction

  task automatic test_directed();
    tick_req_t t;
    t = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
    repeat (3) send_tick(t);
    t = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000};
    send_tick(t);
    t = '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
    send_tick(t);
    t = '{32'shFFFFFFFF, 32'sh55555555, 32'shAAAAAAAA, 32'sh00000001};
    send_tick(t);
    drain();
    write_reg(CFG_PIN_END, 32'd1);
    write_reg(CFG_SEG_LEN, 32'd0);
    t = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF};
    repeat (3) send_tick(t);
    drain();
    write_reg(CFG_SEG_LEN, 32'h7FFFFFFF);
    write_reg(CFG_ELASTICITY, 32'h1FFFF);
    write_reg(CFG_DAMPING, 32'h1FFFF);
    t = '{32'sd0, 32'sh80000000, 32'sd0, 32'sh7FFFFFFF};
    repeat (3) send_tick(t);
    drain();
    write_reg(CFG_ELASTICITY, 32'd0);
    write_reg(CFG_DAMPING, 32'd0);
    write_reg(CFG_PIN_END, 32'd0);
    write_reg(CFG_SEG_LEN, 32'd1);
    t = '{32'sd65536, -32'sd65536, 32'sd0, 32'sd0};
    repeat (3) send_tick(t);
    drain();
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 60 == 0) begin
        drain();
        write_reg(CFG_SEG_LEN, $urandom_range(3, 0) == 0 ? $urandom : $urandom_range(4 * 65536, 1));
        write_reg(CFG_ELASTICITY, $urandom_range(65536, 0));
        write_reg(CFG_DAMPING, $urandom_range(3, 0) == 0 ? 32'd65536 : $urandom_range(65536, 0));
        write_reg(CFG_PIN_END, $urandom_range(1, 0));
        case ((k / 60) % 4)
          0: begin send_idle_pct = 0; recv_stall_pct = 0; end
          1: begin send_idle_pct = 87; recv_stall_pct = 0; end
          2: begin send_idle_pct = 0; recv_stall_pct = 87; end
          default: begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
      end
      send_tick(rand_tick());
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = ~hold_req;
    repeat (4) send_tick(rand_tick());
    drain();
  endtask

  // Receiver: random stalls plus a counted hold-off when requested.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_off <= HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    point_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected point %0d", out_ch.point_index);
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (out_ch.point_index !== e.point_index) begin
          $error("point_index exp %0d got %0d", e.point_index, out_ch.point_index);
          errors++;
        end
        if (out_ch.pos_x !== e.pos_x) begin
          $error("pos_x exp %0d got %0d", e.pos_x, out_ch.pos_x);
          errors++;
        end
        if (out_ch.pos_y !== e.pos_y) begin
          $error("pos_y exp %0d got %0d", e.pos_y, out_ch.pos_y);
          errors++;
        end
        if (out_ch.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or point.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= LIMIT) begin
      $display("** verlet_rope_step: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.base_x = '0;
    in_ch.base_y = '0;
    in_ch.end_x = '0;
    in_ch.end_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SEG_LEN;
    cfg_ch.data = '0;
    seg_len = 31'd65536;
    elast = 17'd32768;
    damp = 17'd64225;
    pin_last = 1'b0;
    laid = 1'b0;
    for (int i = 0; i < NUM_POINTS; i++) begin
      px[i] = '0; py[i] = '0; ox[i] = '0; oy[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(340);
    done = 1'b1;
    if (errors == 0 && expected_points.size() == 0) begin
      $display("** verlet_rope_step: PASSED **");
    end else begin
      $display("** verlet_rope_step: FAILED **");
    end
    $finish;
  end
endmodule
